// File: rtl/core/cag_pkg.sv
// Shared types and constants for the 3-D growth automaton.
`timescale 1ns / 1ps

package cag_pkg;

  // Default side length of the cubic grid
  localparam int GRID_SIDE_DEF = 16;

  // Result field widths
  localparam int BIRTHS_W = 13;
  localparam logic [BIRTHS_W-1:0] BIRTHS_MAX = {BIRTHS_W{1'b1}};

  // Item opcodes; the fourth code is unused and only returns a zero result
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_GEN   = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_GEN,
    ST_GEN_DONE
  } state_e;

  // Which neighbour directions of the centre cell lie inside the grid
  typedef struct packed {
    logic x_lo;
    logic x_hi;
    logic y_lo;
    logic y_hi;
    logic z_lo;
    logic z_hi;
  } cag_bound_t;

endpackage

// File: rtl/core/cag_cell.sv
// One storage cell of the sweep chain: holds one grid bit, passes it on per shift.
`timescale 1ns / 1ps

module cag_cell (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic shift_i,
  input  logic d_i,
  output logic q_o
);

  logic bit_q;

  // Take the neighbour's bit on every shift
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= 1'b0;
    end else if (shift_i) begin
      bit_q <= d_i;
    end
  end

  assign q_o = bit_q;

endmodule

// File: rtl/core/cag_window.sv
// Chain of cells spanning two planes plus two rows; evaluates the growth rule at its centre.
`timescale 1ns / 1ps

module cag_window
  import cag_pkg::*;
#(
  parameter int GRID_SIDE = GRID_SIDE_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       shift_i,
  input  logic       bit_i,
  input  cag_bound_t bound_i,
  output logic       hit_o,
  output logic       centre_o
);

  // Distance from the newest cell to the centre, in raster order
  localparam int Centre   = GRID_SIDE * GRID_SIDE + GRID_SIDE + 1;
  localparam int ChainLen = 2 * Centre + 1;

  logic [ChainLen-1:0] chain;
  logic [26:0]         nb;

  // Row of cells, newest bit at index 0
  for (genvar i = 0; i < ChainLen; i++) begin : g_cell
    if (i == 0) begin : g_head
      cag_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .shift_i(shift_i),
        .d_i    (bit_i),
        .q_o    (chain[i])
      );
    end else begin : g_body
      cag_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .shift_i(shift_i),
        .d_i    (chain[i-1]),
        .q_o    (chain[i])
      );
    end
  end

  // Moore neighbourhood taps, masked where the neighbour leaves the grid
  for (genvar n = 0; n < 27; n++) begin : g_tap
    localparam int Dx  = n / 9 - 1;
    localparam int Dy  = (n / 3) % 3 - 1;
    localparam int Dz  = n % 3 - 1;
    localparam int Off = Dx * GRID_SIDE * GRID_SIDE + Dy * GRID_SIDE + Dz;
    if (n == 13) begin : g_self
      assign nb[n] = 1'b0;
    end else begin : g_nb
      logic ok_x, ok_y, ok_z;
      assign ok_x  = (Dx < 0) ? bound_i.x_lo : ((Dx > 0) ? bound_i.x_hi : 1'b1);
      assign ok_y  = (Dy < 0) ? bound_i.y_lo : ((Dy > 0) ? bound_i.y_hi : 1'b1);
      assign ok_z  = (Dz < 0) ? bound_i.z_lo : ((Dz > 0) ? bound_i.z_hi : 1'b1);
      assign nb[n] = chain[Centre-Off] & ok_x & ok_y & ok_z;
    end
  end

  // Exactly one live neighbour
  assign hit_o    = (nb != '0) && ((nb & (nb - 27'd1)) == '0);
  assign centre_o = chain[Centre];

endmodule

// File: rtl/core/cellular_automaton_3d_growth.sv
// Top level of the 3-D growth automaton: grid memory, sweep sequencer and result register.
`timescale 1ns / 1ps

// A cubic grid of GRID_SIDE^3 one-bit cells lives in a single-bit-wide memory.
// Writes set a cell and return a zero result in the next cycle; reads register
// the cell from memory, then load it into the result register; a generation
// streams the whole grid in raster order through a chain of 2*S*S+2*S+3 cells
// (S = GRID_SIDE) that exposes every 26-cell neighbourhood, writing each new
// cell back one per cycle. Any item is accepted only after the previous one's
// result has been produced. After reset a clearing pass zeroes the grid while
// input stays stalled.
module cellular_automaton_3d_growth
  import cag_pkg::*;
#(
  parameter int GRID_SIDE = GRID_SIDE_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          opcode_i,
  input  logic [3:0]          cell_x_i,
  input  logic [3:0]          cell_y_i,
  input  logic [3:0]          cell_z_i,
  input  logic                write_value_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                cell_value_o,
  output logic [BIRTHS_W-1:0] births_o
);

  localparam int CellCount = GRID_SIDE * GRID_SIDE * GRID_SIDE;
  localparam int IdxW      = $clog2(CellCount);
  localparam int CoW       = $clog2(GRID_SIDE);
  localparam int Centre    = GRID_SIDE * GRID_SIDE + GRID_SIDE + 1;
  localparam int SweepLen  = CellCount + Centre;
  localparam int CntW      = $clog2(SweepLen + 1);

  localparam logic [IdxW-1:0] SideIdx  = IdxW'(GRID_SIDE);
  localparam logic [IdxW-1:0] LastIdx  = IdxW'(CellCount - 1);
  localparam logic [CoW-1:0]  LastCo   = CoW'(GRID_SIDE - 1);
  localparam logic [CntW-1:0] CellsCnt = CntW'(CellCount);
  localparam logic [CntW-1:0] SweepCnt = CntW'(SweepLen);
  localparam logic [CntW-1:0] CentCnt  = CntW'(Centre);

  state_e state_q, state_d;
  op_e    op;

  logic            in_accept, out_free, in_grid;
  logic [IdxW-1:0] in_idx;

  logic [IdxW-1:0] clr_q;
  logic [CntW-1:0] rd_ptr_q, fill_q;
  logic            shift_q, shift_zero_q;
  logic [CoW-1:0]  cx_q, cy_q, cz_q;
  logic [IdxW-1:0] ctr_q;
  logic [BIRTHS_W-1:0] births_q;
  logic            rd_inside_q;

  logic            eval, last_eval, hit, centre, birth;
  cag_bound_t      bound;

  logic            mem_we, mem_wd, mem_re;
  logic [IdxW-1:0] mem_wa, mem_ra;
  logic            grid_mem [CellCount];
  logic            mem_rd_q;

  logic                out_load, out_cell_d;
  logic [BIRTHS_W-1:0] out_births_d;
  logic                out_valid_q, cell_value_q;
  logic [BIRTHS_W-1:0] births_out_q;

  // Handshake and decode of the incoming transaction
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign op         = op_e'(opcode_i);
  assign in_grid    = (int'(cell_x_i) < GRID_SIDE) && (int'(cell_y_i) < GRID_SIDE) &&
                      (int'(cell_z_i) < GRID_SIDE);
  assign in_idx     = (IdxW'(cell_x_i) * SideIdx + IdxW'(cell_y_i)) * SideIdx +
                      IdxW'(cell_z_i);

  // Centre of the window is valid once it has passed the chain's midpoint
  assign eval      = (state_q == ST_GEN) && (fill_q > CentCnt);
  assign last_eval = eval && (ctr_q == LastIdx);
  assign birth     = eval && hit && !centre;

  assign bound.x_lo = (cx_q != '0);
  assign bound.x_hi = (cx_q != LastCo);
  assign bound.y_lo = (cy_q != '0);
  assign bound.y_hi = (cy_q != LastCo);
  assign bound.z_lo = (cz_q != '0);
  assign bound.z_hi = (cz_q != LastCo);

  cag_window #(
    .GRID_SIDE(GRID_SIDE)
  ) u_cag_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (shift_q),
    .bit_i   (shift_zero_q ? 1'b0 : mem_rd_q),
    .bound_i (bound),
    .hit_o   (hit),
    .centre_o(centre)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == LastIdx) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_accept) begin
          case (op)
            OP_READ: state_d = ST_READ;
            OP_GEN:  state_d = ST_GEN;
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_READ: begin
        if (out_free) state_d = ST_IDLE;
      end
      ST_GEN: begin
        if (last_eval) state_d = ST_GEN_DONE;
      end
      ST_GEN_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Memory ports and result loading
  always_comb begin
    mem_we       = 1'b0;
    mem_wa       = '0;
    mem_wd       = 1'b0;
    mem_re       = 1'b0;
    mem_ra       = '0;
    out_load     = 1'b0;
    out_cell_d   = 1'b0;
    out_births_d = '0;
    case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_q;
      end
      ST_IDLE: begin
        if (in_accept) begin
          case (op)
            OP_WRITE: begin
              mem_we   = in_grid;
              mem_wa   = in_idx;
              mem_wd   = write_value_i;
              out_load = 1'b1;
            end
            OP_READ: begin
              mem_re = 1'b1;
              mem_ra = in_idx;
            end
            OP_GEN: begin
              out_load = 1'b0;
            end
            default: out_load = 1'b1;
          endcase
        end
      end
      ST_READ: begin
        out_load   = out_free;
        out_cell_d = mem_rd_q & rd_inside_q;
      end
      ST_GEN: begin
        mem_re = (rd_ptr_q < CellsCnt);
        mem_ra = rd_ptr_q[IdxW-1:0];
        mem_we = eval;
        mem_wa = ctr_q;
        mem_wd = centre | hit;
      end
      ST_GEN_DONE: begin
        out_load     = out_free;
        out_births_d = births_q;
      end
      default: out_load = 1'b0;
    endcase
  end

  // Grid memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) grid_mem[mem_wa] <= mem_wd;
    if (mem_re) mem_rd_q <= grid_mem[mem_ra];
  end

  // State and clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + IdxW'(1);
    end
  end

  // Sweep counters and births tally
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q     <= '0;
      fill_q       <= '0;
      shift_q      <= 1'b0;
      shift_zero_q <= 1'b0;
      cx_q         <= '0;
      cy_q         <= '0;
      cz_q         <= '0;
      ctr_q        <= '0;
      births_q     <= '0;
      rd_inside_q  <= 1'b0;
    end else begin
      shift_q      <= (state_q == ST_GEN) && (rd_ptr_q < SweepCnt);
      shift_zero_q <= (rd_ptr_q >= CellsCnt);
      if (in_accept && op == OP_READ) rd_inside_q <= in_grid;
      if (in_accept && op == OP_GEN) begin
        rd_ptr_q <= '0;
        fill_q   <= '0;
        cx_q     <= '0;
        cy_q     <= '0;
        cz_q     <= '0;
        ctr_q    <= '0;
        births_q <= '0;
      end else begin
        if (state_q == ST_GEN && rd_ptr_q < SweepCnt) rd_ptr_q <= rd_ptr_q + CntW'(1);
        if (shift_q) fill_q <= fill_q + CntW'(1);
        if (eval) begin
          ctr_q <= ctr_q + IdxW'(1);
          if (cz_q == LastCo) begin
            cz_q <= '0;
            if (cy_q == LastCo) begin
              cy_q <= '0;
              cx_q <= cx_q + CoW'(1);
            end else begin
              cy_q <= cy_q + CoW'(1);
            end
          end else begin
            cz_q <= cz_q + CoW'(1);
          end
        end
        // Saturating count of new cells
        if (birth && births_q != BIRTHS_MAX) births_q <= births_q + BIRTHS_W'(1);
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      cell_value_q <= out_cell_d;
      births_out_q <= out_births_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign cell_value_o = cell_value_q;
  assign births_o     = births_out_q;

endmodule

// File: rtl/core/cag_checker.sv
// Port-level checks for the 3-D growth automaton, bound to the top level.
`timescale 1ns / 1ps

module cag_checker
  import cag_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic [1:0]          opcode_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic                cell_value_o,
  input logic [BIRTHS_W-1:0] births_o
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // A held result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(cell_value_o) && $stable(births_o))
    else $error("result changed while stalled");

  // A result never carries both a read bit and a birth count
  a_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(cell_value_o && births_o != '0))
    else $error("read bit and births both set");

  // A write transaction answers at once with a zero result
  a_write_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && opcode_i == OP_WRITE |=> out_valid_o && !cell_value_o && births_o == '0)
    else $error("write result missing or non-zero");

  // Reads and generations keep the input stalled while they run
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (opcode_i == OP_READ || opcode_i == OP_GEN) |=> in_stall_o)
    else $error("input taken while item in progress");

endmodule

bind cellular_automaton_3d_growth cag_checker u_cag_checker (.*);

// File: sim/tb_top.sv
// Self-checking testbench for the 3-D growth automaton: grid writes, reads and generations.
`timescale 1ns / 1ps

module tb_top;
  import cag_pkg::*;

  localparam int SIDE  = GRID_SIDE_DEF;
  localparam int CELLS = SIDE * SIDE * SIDE;
  // spare opcode: changes nothing, returns an all-zero result
  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_OFF    = 300;
  localparam int RANDOM_CMDS = 120;

  typedef struct packed {
    logic [1:0] opcode;
    logic [3:0] x;
    logic [3:0] y;
    logic [3:0] z;
    logic       wval;
  } cell_cmd_t;

  typedef struct packed {
    logic                cell_value;
    logic [BIRTHS_W-1:0] births;
  } cell_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [1:0]          opcode_i = 2'd0;
  logic [3:0]          cell_x_i = 4'd0;
  logic [3:0]          cell_y_i = 4'd0;
  logic [3:0]          cell_z_i = 4'd0;
  logic                write_value_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic                cell_value_o;
  logic [BIRTHS_W-1:0] births_o;

  // Shadow grid and transaction bookkeeping
  bit           grid_now [CELLS];
  bit           grid_next [CELLS];
  cell_cmd_t    cmd_q [$];
  cell_result_t due_results [$];
  logic         in_taken = 1'b0;
  logic         out_taken = 1'b0;
  int           items_taken = 0;
  int           results_seen = 0;
  int           mismatch_count = 0;
  int           idle_cycles = 0;
  int           tx_gap = 0;
  int           tx_burst = 0;
  int           rx_wait = 0;
  int           rx_burst = 0;
  int           rx_hold = 0;

  cellular_automaton_3d_growth dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .opcode_i      (opcode_i),
    .cell_x_i      (cell_x_i),
    .cell_y_i      (cell_y_i),
    .cell_z_i      (cell_z_i),
    .write_value_i (write_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .cell_value_o  (cell_value_o),
    .births_o      (births_o)
  );

  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch: %s got %0d want %0d at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // One generation: a cell with exactly one live neighbour becomes live
  function automatic logic [BIRTHS_W-1:0] grow_one_generation();
    int born;
    int live;
    int nx, ny, nz, idx;
    born = 0;
    for (int x = 0; x < SIDE; x++) begin
      for (int y = 0; y < SIDE; y++) begin
        for (int z = 0; z < SIDE; z++) begin
          live = 0;
          for (int dx = -1; dx <= 1; dx++) begin
            for (int dy = -1; dy <= 1; dy++) begin
              for (int dz = -1; dz <= 1; dz++) begin
                nx = x + dx;
                ny = y + dy;
                nz = z + dz;
                if ((dx | dy | dz) != 0 && nx >= 0 && ny >= 0 && nz >= 0 &&
                    nx < SIDE && ny < SIDE && nz < SIDE)
                  live += grid_now[(nx * SIDE + ny) * SIDE + nz];
              end
            end
          end
          idx = (x * SIDE + y) * SIDE + z;
          if (live == 1) begin
            if (!grid_next[idx]) born++;
            grid_next[idx] = 1'b1;
          end
        end
      end
    end
    grid_now = grid_next;
    return (born > BIRTHS_MAX) ? BIRTHS_MAX : born[BIRTHS_W-1:0];
  endfunction

  // Result of one transaction; 4-bit coordinates always fall inside a side-16 grid
  function automatic cell_result_t apply_grid_cmd(input cell_cmd_t c);
    cell_result_t r;
    int idx;
    r = '0;
    idx = (int'(c.x) * SIDE + int'(c.y)) * SIDE + int'(c.z);
    case (c.opcode)
      OP_WRITE: begin
        grid_now[idx]  = c.wval;
        grid_next[idx] = c.wval;
      end
      OP_GEN:  r.births = grow_one_generation();
      OP_READ: r.cell_value = grid_now[idx];
      default: ;
    endcase
    return r;
  endfunction

  task automatic queue_cmd(input logic [1:0] op, input int x, input int y, input int z,
                           input bit v);
    cell_cmd_t c;
    c.opcode = op;
    c.x = x[3:0];
    c.y = y[3:0];
    c.z = z[3:0];
    c.wval = v;
    cmd_q.push_back(c);
  endtask

  // Mostly near the middle so reads find live cells, sometimes anywhere
  function automatic int pick_coord();
    return ($urandom_range(0, 9) < 7) ? $urandom_range(5, 10) : $urandom_range(0, SIDE - 1);
  endfunction

  // Sender: present queued transactions, random gap after each acceptance
  always @(negedge clk_i) begin : drive_cmds
    logic      offer;
    cell_cmd_t cur;
    if (rst_ni) begin
      offer = in_valid_i;
      if (in_valid_i && in_taken) begin
        offer = 1'b0;
        if (tx_burst > 0) begin
          tx_burst--;
          tx_gap = 0;
        end else if ($urandom_range(0, 7) == 0) begin
          tx_burst = $urandom_range(4, 16);
          tx_gap = 0;
        end else begin
          tx_gap = $urandom_range(0, 10);
        end
      end
      if (!offer) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (cmd_q.size() != 0) begin
          cur = cmd_q.pop_front();
          opcode_i      <= cur.opcode;
          cell_x_i      <= cur.x;
          cell_y_i      <= cur.y;
          cell_z_i      <= cur.z;
          write_value_i <= cur.wval;
          offer = 1'b1;
        end
      end
      in_valid_i <= offer;
    end
  end

  // Receiver: random stall after each result, two long hold-offs
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_taken) begin
        if (rx_burst > 0) begin
          rx_burst--;
          rx_wait = 0;
        end else if ($urandom_range(0, 7) == 0) begin
          rx_burst = $urandom_range(4, 16);
          rx_wait = 0;
        end else begin
          rx_wait = $urandom_range(0, 10);
        end
        if (results_seen == 30 || results_seen == 110) rx_hold = HOLD_OFF;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_stall_i <= 1'b1;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Monitor: check results, then fold accepted transactions into the shadow grid
  always @(posedge clk_i) begin : watch_ports
    cell_result_t want;
    cell_cmd_t    got_cmd;
    logic         in_fire;
    logic         out_fire;
    if (rst_ni) begin
      in_fire  = in_valid_i && !in_stall_o;
      out_fire = out_valid_o && !out_stall_i;
      in_taken  <= in_fire;
      out_taken <= out_fire;
      if (out_fire) begin
        results_seen++;
        if (due_results.size() == 0) begin
          report_mismatch("result with nothing outstanding, births", births_o, 0);
        end else begin
          want = due_results.pop_front();
          if (cell_value_o !== want.cell_value)
            report_mismatch("cell_value", cell_value_o, want.cell_value);
          if (births_o !== want.births)
            report_mismatch("births", births_o, want.births);
        end
      end
      if (in_fire) begin
        items_taken++;
        got_cmd.opcode = opcode_i;
        got_cmd.x      = cell_x_i;
        got_cmd.y      = cell_y_i;
        got_cmd.z      = cell_z_i;
        got_cmd.wval   = write_value_i;
        due_results.push_back(apply_grid_cmd(got_cmd));
      end
      // watchdog on cycles with no transaction on either side
      idle_cycles = (in_fire || out_fire) ? 0 : idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  initial begin : run_test
    int n_items;
    int r;
    // corners, overwrite with dead, spare opcode, growth from seeds
    queue_cmd(OP_WRITE, 0, 0, 0, 1'b1);
    queue_cmd(OP_WRITE, 15, 15, 15, 1'b1);
    queue_cmd(OP_READ, 0, 0, 0, 1'b0);
    queue_cmd(OP_READ, 15, 15, 15, 1'b1);
    queue_cmd(OP_READ, 15, 0, 15, 1'b0);
    queue_cmd(OP_WRITE, 8, 8, 8, 1'b1);
    queue_cmd(OP_WRITE, 8, 8, 8, 1'b0);
    queue_cmd(OP_READ, 8, 8, 8, 1'b1);
    queue_cmd(OP_SPARE, 15, 15, 15, 1'b1);
    queue_cmd(OP_GEN, 0, 0, 0, 1'b0);
    queue_cmd(OP_READ, 1, 1, 1, 1'b0);
    queue_cmd(OP_READ, 14, 15, 15, 1'b0);
    queue_cmd(OP_READ, 2, 2, 2, 1'b0);
    queue_cmd(OP_WRITE, 7, 7, 7, 1'b1);
    queue_cmd(OP_GEN, 15, 15, 15, 1'b1);
    queue_cmd(OP_READ, 2, 2, 2, 1'b0);
    queue_cmd(OP_READ, 6, 6, 6, 1'b0);
    queue_cmd(OP_WRITE, 6, 6, 6, 1'b0);
    queue_cmd(OP_READ, 6, 6, 6, 1'b0);
    queue_cmd(OP_SPARE, 0, 0, 0, 1'b0);

    // random mix, generations kept sparse as each one sweeps the whole grid
    for (int i = 0; i < RANDOM_CMDS; i++) begin
      r = $urandom_range(0, 99);
      if (r < 38)
        queue_cmd(OP_WRITE, pick_coord(), pick_coord(), pick_coord(),
                  $urandom_range(0, 3) != 0);
      else if (r < 76)
        queue_cmd(OP_READ, pick_coord(), pick_coord(), pick_coord(), $urandom_range(0, 1));
      else if (r < 90)
        queue_cmd(OP_GEN, $urandom_range(0, 15), $urandom_range(0, 15),
                  $urandom_range(0, 15), $urandom_range(0, 1));
      else
        queue_cmd(OP_SPARE, $urandom_range(0, 15), $urandom_range(0, 15),
                  $urandom_range(0, 15), $urandom_range(0, 1));
    end
    n_items = cmd_q.size();

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (items_taken != n_items || due_results.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);

    if (mismatch_count == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule

// File: cellular_automaton_3d_growth.f
rtl/core/cag_pkg.sv
rtl/core/cag_cell.sv
rtl/core/cag_window.sv
rtl/core/cellular_automaton_3d_growth.sv
rtl/core/cag_checker.sv
sim/tb_top.sv
